>>> hdl/fcm_dfcm_double_compressor_unit_defines.svh
// Assertion macros shared by the compressor RTL files.
`ifndef FCM_DFCM_DOUBLE_COMPRESSOR_UNIT_DEFINES_SVH
`define FCM_DFCM_DOUBLE_COMPRESSOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define FCM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define FCM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/fcm_pkg.sv
// Package with the payload types, register codes and reset values of the compressor.
`default_nettype none

package fcm_pkg;

   typedef struct packed {
      logic [63:0] sample_value;
      logic        last_in_block;
   } req_type;

   typedef struct packed {
      logic        stride_selected;
      logic [2:0]  size_code;
      logic [63:0] residual;
      logic [3:0]  residual_bytes;
      logic        block_end;
   } rsp_type;

   // Both candidate residuals of one item, handed from the predict stage to the select stage.
   typedef struct packed {
      logic [63:0] value_residual;
      logic [63:0] stride_residual;
      logic        block_end;
   } cand_type;

   // Per-cycle control from the top level to each predictor.
   typedef struct packed {
      logic accept;
      logic last;
      logic clearing;
   } pred_ctl_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VALUE_LEFT_SHIFT   = 3'd0,
      CSR_VALUE_RIGHT_SHIFT  = 3'd1,
      CSR_STRIDE_LEFT_SHIFT  = 3'd2,
      CSR_STRIDE_RIGHT_SHIFT = 3'd3,
      CSR_TABLE_SIZE_LOG2    = 3'd4
   } csr_index_type;

   localparam logic [4:0] VALUE_LEFT_SHIFT_RESET   = 5'd6;
   localparam logic [5:0] VALUE_RIGHT_SHIFT_RESET  = 6'd48;
   localparam logic [4:0] STRIDE_LEFT_SHIFT_RESET  = 5'd2;
   localparam logic [5:0] STRIDE_RIGHT_SHIFT_RESET = 6'd40;
   localparam logic [3:0] TABLE_SIZE_LOG2_RESET    = 4'd12;

endpackage

`default_nettype wire

>>> hdl/fcm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module fcm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read returns the contents before a write to the same address in this cycle.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/fcm_predictor.sv
// One hashed predictor: running hash, table memory, and the prediction it reads back.
`default_nettype none

`include "fcm_dfcm_double_compressor_unit_defines.svh"

module fcm_predictor
   import fcm_pkg::*;
#(
   parameter int TABLE_LOG2 = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pred_ctl_type          ctl,
   input  wire logic [TABLE_LOG2-1:0] clear_addr,
   input  wire logic [63:0]           mix_value,
   input  wire logic [4:0]            left_shift,
   input  wire logic [5:0]            right_shift,
   input  wire logic [TABLE_LOG2-1:0] index_mask,
   output logic      [63:0]           prediction
);

   localparam int DEPTH = 2 ** TABLE_LOG2;

   logic [TABLE_LOG2-1:0] hash_ff, hash_in;
   logic [TABLE_LOG2-1:0] next_index;
   logic [TABLE_LOG2-1:0] shifted_hash;
   logic [63:0]           shifted_mix;
   logic                  zero_ff, zero_in;
   logic                  fwd_ff, fwd_in;
   logic [63:0]           fwd_data_ff, fwd_data_in;
   logic                  wr_en;
   logic [TABLE_LOG2-1:0] wr_addr;
   logic [63:0]           wr_data;
   logic [63:0]           rd_data;

   // Bits shifted above the index width are dropped, as the mask would drop them.
   assign shifted_hash = TABLE_LOG2'(hash_ff << left_shift);
   assign shifted_mix  = mix_value >> right_shift;
   assign next_index   = (shifted_hash ^ shifted_mix[TABLE_LOG2-1:0]) & index_mask;

   always_comb begin
      wr_en   = ctl.accept || ctl.clearing;
      wr_addr = ctl.clearing ? clear_addr : hash_ff;
      wr_data = ctl.clearing ? 64'd0 : mix_value;
   end

   always_comb begin
      hash_in     = hash_ff;
      zero_in     = zero_ff;
      fwd_in      = fwd_ff;
      fwd_data_in = fwd_data_ff;
      if (ctl.accept) begin
         hash_in     = ctl.last ? '0 : next_index;
         zero_in     = ctl.last;
         // The read below sees the old entry; forward this item's write on a hit.
         fwd_in      = (next_index == hash_ff);
         fwd_data_in = mix_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
         zero_ff <= 1'b1;
         fwd_ff  <= 1'b0;
      end else begin
         hash_ff <= hash_in;
         zero_ff <= zero_in;
         fwd_ff  <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= fwd_data_in;
   end

   fcm_ram #(
      .WIDTH (64),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.accept),
      .rd_addr (next_index),
      .rd_data (rd_data)
   );

   assign prediction = zero_ff ? 64'd0 : (fwd_ff ? fwd_data_ff : rd_data);

   `FCM_ASSERT_NEXT(a_block_end_zero, clock, reset, ctl.accept && ctl.last,
      prediction == 64'd0, "prediction not cleared after block end")
   `FCM_ASSERT_NEXT(a_same_entry_fwd, clock, reset,
      ctl.accept && !ctl.last && (next_index == hash_ff),
      prediction == $past(mix_value), "same-entry write not forwarded")

endmodule

`default_nettype wire

>>> hdl/fcm_selector.sv
// Select stage: pick the smaller residual, code its length and hold the result item.
`default_nettype none

`include "fcm_dfcm_double_compressor_unit_defines.svh"

module fcm_selector
   import fcm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     cand_valid,
   input  wire cand_type cand,
   output logic          cand_take,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_payload
);

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        out_free;
   logic        use_stride;
   logic [63:0] chosen;
   logic [2:0]  code;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cand_take = cand_valid && out_free;

   // Tie goes to the value predictor.
   assign use_stride = cand.value_residual > cand.stride_residual;
   assign chosen     = use_stride ? cand.stride_residual : cand.value_residual;

   always_comb begin
      if (chosen[63:56] != 8'd0) begin
         code = 3'd7;
      end else if (chosen[55:48] != 8'd0) begin
         code = 3'd6;
      end else if (chosen[47:40] != 8'd0) begin
         code = 3'd5;
      end else if (chosen[39:24] != 16'd0) begin
         code = 3'd4;
      end else if (chosen[23:16] != 8'd0) begin
         code = 3'd3;
      end else if (chosen[15:8] != 8'd0) begin
         code = 3'd2;
      end else if (chosen[7:0] != 8'd0) begin
         code = 3'd1;
      end else begin
         code = 3'd0;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cand_take) begin
         rsp_in.stride_selected = use_stride;
         rsp_in.size_code       = code;
         rsp_in.residual        = chosen;
         rsp_in.residual_bytes  = {1'b0, code} + {3'b000, code[2]};
         rsp_in.block_end       = cand.block_end;
         rsp_valid_in           = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `FCM_ASSERT_NOW(a_bytes_cover_residual, clock, reset, rsp_valid_ff,
      (rsp_ff.residual_bytes == 4'd8) ||
      ((rsp_ff.residual >> {rsp_ff.residual_bytes, 3'b000}) == 64'd0),
      "residual has significant bytes beyond residual_bytes")

endmodule

`default_nettype wire

>>> hdl/fcm_dfcm_double_compressor_unit.sv
// Top level of the two-predictor double compressor front end.
//
// One 64-bit value enters per item and one result item leaves per item, in order. The block
// sustains one item per clock while it is not clearing and the output is not stalled: each
// accepted item writes both predictor memories at the current hash and, in the same cycle,
// reads the next predictions at the new hash, so the registered read is ready for the
// following item. An accepted item is loaded into the candidate register and then, once the
// output register is free, into the output register, whose valid bit drives rsp_valid. After
// reset the block clears all 2**TABLE_LOG2 entries of both tables (4096 at the default), one
// entry per cycle, and holds req_stall high meanwhile; configuration writes are taken at any
// time and csr_ready is always high. Change the registers only while the block is idle.
// The tables persist across blocks; an item with last_in_block set returns the hashes, the
// previous value and both predictions to zero.
`default_nettype none

`include "fcm_dfcm_double_compressor_unit_defines.svh"

module fcm_dfcm_double_compressor_unit
   import fcm_pkg::*;
#(
   parameter int TABLE_LOG2 = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input items
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_payload,
   // result items
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_payload,
   // configuration writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers
   logic [4:0] value_left_ff,   value_left_in;
   logic [5:0] value_right_ff,  value_right_in;
   logic [4:0] stride_left_ff,  stride_left_in;
   logic [5:0] stride_right_ff, stride_right_in;
   logic [3:0] size_log2_ff,    size_log2_in;

   // Table clearing pass after reset
   logic                  clearing_ff, clearing_in;
   logic [TABLE_LOG2-1:0] clear_addr_ff, clear_addr_in;

   // Predict stage
   logic                  accept;
   logic [63:0]           previous_ff, previous_in;
   logic [63:0]           value_pred, stride_pred;
   logic [63:0]           stride;
   logic [TABLE_LOG2-1:0] index_mask;
   pred_ctl_type          pred_ctl;
   logic                  cand_valid_ff, cand_valid_in;
   cand_type              cand_ff, cand_in;
   logic                  cand_take;

   // ---------------------------------------------------------------- configuration
   assign csr_ready = 1'b1;

   always_comb begin
      value_left_in   = value_left_ff;
      value_right_in  = value_right_ff;
      stride_left_in  = stride_left_ff;
      stride_right_in = stride_right_ff;
      size_log2_in    = size_log2_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_VALUE_LEFT_SHIFT:   value_left_in   = csr_wdata[4:0];
            CSR_VALUE_RIGHT_SHIFT:  value_right_in  = csr_wdata[5:0];
            CSR_STRIDE_LEFT_SHIFT:  stride_left_in  = csr_wdata[4:0];
            CSR_STRIDE_RIGHT_SHIFT: stride_right_in = csr_wdata[5:0];
            CSR_TABLE_SIZE_LOG2:    size_log2_in    = csr_wdata[3:0];
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_left_ff   <= VALUE_LEFT_SHIFT_RESET;
         value_right_ff  <= VALUE_RIGHT_SHIFT_RESET;
         stride_left_ff  <= STRIDE_LEFT_SHIFT_RESET;
         stride_right_ff <= STRIDE_RIGHT_SHIFT_RESET;
         size_log2_ff    <= TABLE_SIZE_LOG2_RESET;
      end else begin
         value_left_ff   <= value_left_in;
         value_right_ff  <= value_right_in;
         stride_left_ff  <= stride_left_in;
         stride_right_ff <= stride_right_in;
         size_log2_ff    <= size_log2_in;
      end
   end

   // Index bit i is live when it lies below the programmed width; a width above
   // TABLE_LOG2 therefore opens the whole index.
   always_comb begin
      for (int i = 0; i < TABLE_LOG2; i++) begin
         index_mask[i] = (i < int'(size_log2_ff));
      end
   end

   // ---------------------------------------------------------------- clearing pass
   always_comb begin
      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + TABLE_LOG2'(1);
         // Stop after the last entry has been written.
         if (clear_addr_ff == {TABLE_LOG2{1'b1}}) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // ---------------------------------------------------------------- predict stage
   // Hold input while clearing, or while the candidate register is full and cannot move on.
   assign req_stall = clearing_ff || (cand_valid_ff && !cand_take);
   assign accept    = req_valid && !req_stall;

   assign stride = req_payload.sample_value - previous_ff;

   always_comb begin
      pred_ctl.accept   = accept;
      pred_ctl.last     = req_payload.last_in_block;
      pred_ctl.clearing = clearing_ff;
   end

   fcm_predictor #(
      .TABLE_LOG2 (TABLE_LOG2)
   ) u_value_pred (
      .clock       (clock),
      .reset       (reset),
      .ctl         (pred_ctl),
      .clear_addr  (clear_addr_ff),
      .mix_value   (req_payload.sample_value),
      .left_shift  (value_left_ff),
      .right_shift (value_right_ff),
      .index_mask  (index_mask),
      .prediction  (value_pred)
   );

   fcm_predictor #(
      .TABLE_LOG2 (TABLE_LOG2)
   ) u_stride_pred (
      .clock       (clock),
      .reset       (reset),
      .ctl         (pred_ctl),
      .clear_addr  (clear_addr_ff),
      .mix_value   (stride),
      .left_shift  (stride_left_ff),
      .right_shift (stride_right_ff),
      .index_mask  (index_mask),
      .prediction  (stride_pred)
   );

   always_comb begin
      previous_in   = previous_ff;
      cand_in       = cand_ff;
      cand_valid_in = cand_valid_ff;
      if (cand_take) begin
         cand_valid_in = 1'b0;
      end
      if (accept) begin
         previous_in             = req_payload.last_in_block ? 64'd0 : req_payload.sample_value;
         cand_in.value_residual  = req_payload.sample_value ^ value_pred;
         cand_in.stride_residual = req_payload.sample_value ^ (previous_ff + stride_pred);
         cand_in.block_end       = req_payload.last_in_block;
         cand_valid_in           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_ff   <= '0;
         cand_valid_ff <= 1'b0;
      end else begin
         previous_ff   <= previous_in;
         cand_valid_ff <= cand_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
   end

   // ---------------------------------------------------------------- select stage
   fcm_selector u_selector (
      .clock       (clock),
      .reset       (reset),
      .cand_valid  (cand_valid_ff),
      .cand        (cand_ff),
      .cand_take   (cand_take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   `FCM_ASSERT_NOW(a_full_pipe_stalls, clock, reset,
      cand_valid_ff && rsp_valid && rsp_stall, req_stall,
      "input taken while both stages are full and the output is stalled")
   `FCM_ASSERT_NEXT(a_clear_blocks_items, clock, reset, clearing_ff && req_valid,
      !cand_valid_ff || $past(cand_valid_ff), "item accepted during table clearing")

endmodule

`default_nettype wire
